// File: src/itp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants for the infix to postfix converter
// Character classes, stack codes, precedence and the command/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package itp_pkg;

  typedef logic [7:0] char_t;
  typedef logic [2:0] code_t;
  typedef logic [1:0] prec_t;

  // Stack entry codes
  localparam code_t CODE_OPEN  = 3'd0;
  localparam code_t CODE_PLUS  = 3'd1;
  localparam code_t CODE_MINUS = 3'd2;
  localparam code_t CODE_MUL   = 3'd3;
  localparam code_t CODE_DIV   = 3'd4;

  // ASCII characters
  localparam char_t CH_OPEN  = 8'h28;
  localparam char_t CH_CLOSE = 8'h29;
  localparam char_t CH_MUL   = 8'h2A;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_DIV   = 8'h2F;
  localparam char_t CH_LO_A  = 8'h61;
  localparam char_t CH_LO_Z  = 8'h7A;
  localparam char_t CH_UP_A  = 8'h41;
  localparam char_t CH_UP_Z  = 8'h5A;
  localparam char_t CH_NUL   = 8'h00;

  localparam prec_t PREC_NONE = 2'd0;
  localparam prec_t PREC_ADD  = 2'd2;
  localparam prec_t PREC_MUL  = 2'd3;

  typedef enum logic [2:0] {
    CLS_LETTER,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP,
    CLS_OTHER
  } cls_t;

  typedef enum logic [1:0] {
    SEL_CHAR,
    SEL_TOP,
    SEL_MARK
  } emit_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHAR,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic      in_valid;
    cls_t      cls;
    logic      last;
    logic      empty;     // stack holds nothing
    logic      top_open;  // top entry is an opening parenthesis
    logic      top_ge;    // top precedence >= precedence of the held operator
    logic      ops_zero;  // no operator on the stack
    logic      ops_one;   // exactly one operator on the stack
    logic      emitted;   // this character already produced a word
    logic      out_free;  // output register can take a word this cycle
  } stat_t;

  typedef struct packed {
    logic      in_ready;
    logic      push;
    logic      pop;
    logic      emit;
    emit_sel_t sel;
    logic      emit_last;
    logic      end_step;
  } cmd_t;

  function automatic cls_t char_class(input char_t c);
    cls_t r;
    if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
      r = CLS_LETTER;
    end else begin
      case (c)
        CH_OPEN:  r = CLS_OPEN;
        CH_CLOSE: r = CLS_CLOSE;
        CH_PLUS:  r = CLS_OP;
        CH_MINUS: r = CLS_OP;
        CH_MUL:   r = CLS_OP;
        CH_DIV:   r = CLS_OP;
        default:  r = CLS_OTHER;
      endcase
    end
    return r;
  endfunction

  function automatic code_t char_code(input char_t c);
    code_t r;
    case (c)
      CH_PLUS:  r = CODE_PLUS;
      CH_MINUS: r = CODE_MINUS;
      CH_MUL:   r = CODE_MUL;
      CH_DIV:   r = CODE_DIV;
      default:  r = CODE_OPEN;
    endcase
    return r;
  endfunction

  function automatic prec_t prec_of(input code_t k);
    prec_t r;
    case (k)
      CODE_PLUS:  r = PREC_ADD;
      CODE_MINUS: r = PREC_ADD;
      CODE_MUL:   r = PREC_MUL;
      CODE_DIV:   r = PREC_MUL;
      default:    r = PREC_NONE;
    endcase
    return r;
  endfunction

  function automatic char_t code_char(input code_t k);
    char_t r;
    case (k)
      CODE_PLUS:  r = CH_PLUS;
      CODE_MINUS: r = CH_MINUS;
      CODE_MUL:   r = CH_MUL;
      CODE_DIV:   r = CH_DIV;
      default:    r = CH_OPEN;
    endcase
    return r;
  endfunction

endpackage

// File: src/itp_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_intf: stream channels of the infix to postfix converter
// Input character channel and postfix result channel, valid/ready.
// ----------------------------------------------------------------------------
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_ch;
  logic       out_empty;
  logic       out_last;
  logic       err_overflow;
  logic       err_paren;

  modport source (output valid, output out_ch, output out_empty, output out_last,
                  output err_overflow, output err_paren, input ready);
  modport sink   (input valid, input out_ch, input out_empty, input out_last,
                  input err_overflow, input err_paren, output ready);
endinterface

// File: src/itp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ctrl: conversion sequencer
// Walks one character through its stack actions, then flushes at the end
// of the expression, one stack action or output word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  itp_pkg::stat_t stat,
  output itp_pkg::cmd_t  cmd
);

  itp_pkg::state_t state_r;
  itp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    logic done;
    done      = 1'b0;
    state_nxt = state_r;
    case (state_r)
      itp_pkg::ST_IDLE: begin
        if (stat.in_valid) begin
          state_nxt = itp_pkg::ST_CHAR;
        end
      end
      itp_pkg::ST_CHAR: begin
        case (stat.cls)
          itp_pkg::CLS_LETTER: done = stat.out_free;
          itp_pkg::CLS_OPEN:   done = 1'b1;
          itp_pkg::CLS_OP:     done = !(!stat.empty && stat.top_ge);
          itp_pkg::CLS_CLOSE:  done = stat.empty || stat.top_open;
          default:             done = 1'b1;
        endcase
        if (done) begin
          state_nxt = stat.last ? itp_pkg::ST_FLUSH : itp_pkg::ST_IDLE;
        end
      end
      itp_pkg::ST_FLUSH: begin
        if (stat.empty && (stat.emitted || stat.out_free)) begin
          state_nxt = itp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = itp_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.sel       = itp_pkg::SEL_CHAR;
    case (state_r)
      itp_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
      end
      itp_pkg::ST_CHAR: begin
        case (stat.cls)
          itp_pkg::CLS_LETTER: begin
            cmd.emit      = stat.out_free;
            cmd.sel       = itp_pkg::SEL_CHAR;
            cmd.emit_last = stat.last && stat.ops_zero;
          end
          itp_pkg::CLS_OPEN: begin
            cmd.push = 1'b1;
          end
          itp_pkg::CLS_OP: begin
            if (!stat.empty && stat.top_ge) begin
              // pop the operator of equal or higher precedence; the push that follows keeps it not last
              cmd.pop  = stat.out_free;
              cmd.emit = stat.out_free;
              cmd.sel  = itp_pkg::SEL_TOP;
            end else begin
              cmd.push = 1'b1;
            end
          end
          itp_pkg::CLS_CLOSE: begin
            if (!stat.empty && !stat.top_open) begin
              cmd.pop       = stat.out_free;
              cmd.emit      = stat.out_free;
              cmd.sel       = itp_pkg::SEL_TOP;
              cmd.emit_last = stat.last && stat.ops_one;
            end else if (!stat.empty) begin
              // drop the matching parenthesis
              cmd.pop = 1'b1;
            end
          end
          default: ;
        endcase
      end
      itp_pkg::ST_FLUSH: begin
        if (!stat.empty) begin
          if (stat.top_open) begin
            cmd.pop = 1'b1;
          end else begin
            cmd.pop       = stat.out_free;
            cmd.emit      = stat.out_free;
            cmd.sel       = itp_pkg::SEL_TOP;
            cmd.emit_last = stat.ops_one;
          end
        end else if (!stat.emitted) begin
          cmd.emit      = stat.out_free;
          cmd.sel       = itp_pkg::SEL_MARK;
          cmd.emit_last = 1'b1;
          cmd.end_step  = stat.out_free;
        end else begin
          cmd.end_step = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: src/itp_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_dpath: operator stack and output register
// Stack memory with a cached top entry and a prefetched entry below it,
// sticky error flags and the result word register.
// ----------------------------------------------------------------------------
module itp_dpath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [7:0]     in_ch,
  input  logic           in_last,
  input  itp_pkg::cmd_t  cmd,
  output itp_pkg::stat_t stat,
  itp_out_if.source      out_bus
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  logic                 accept;
  itp_pkg::code_t       mem [STACK_DEPTH];
  itp_pkg::code_t       rd_data_r;
  logic [IW-1:0]        rd_addr;

  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        opens_r, opens_nxt;
  logic [CW-1:0]        ops;
  itp_pkg::code_t       top_r;
  logic                 full;
  logic                 do_push;
  itp_pkg::code_t       push_code;

  itp_pkg::char_t       ch_r;
  logic                 last_r;
  itp_pkg::cls_t        cls_r;
  itp_pkg::code_t       code_r;
  logic                 stopped_r;
  logic                 ovf_r;
  logic                 paren_r;
  logic                 emitted_r;

  itp_pkg::cls_t        cls_in;
  itp_pkg::code_t       code_in;
  logic                 in_top_ge;
  logic                 ovf_new;
  logic                 open_pushed;
  logic                 close_matched;
  logic                 opens_left;
  logic                 paren_new;

  logic                 out_valid_r;
  itp_pkg::char_t       out_ch_r;
  logic                 out_empty_r;
  logic                 out_last_r;
  logic                 out_ovf_r;
  logic                 out_paren_r;
  logic                 out_free;

  assign accept   = in_valid && cmd.in_ready;
  assign full     = (count_r == CW'(STACK_DEPTH));
  assign ops      = count_r - opens_r;
  assign out_free = !out_valid_r || out_bus.ready;
  assign push_code = (cls_r == itp_pkg::CLS_OPEN) ? itp_pkg::CODE_OPEN : code_r;
  assign do_push  = cmd.push && !full;

  // Decide this character's error flags up front from the stack summary
  assign cls_in        = stopped_r ? itp_pkg::CLS_OTHER : itp_pkg::char_class(in_ch);
  assign code_in       = itp_pkg::char_code(in_ch);
  assign in_top_ge     = (itp_pkg::prec_of(top_r) >= itp_pkg::prec_of(code_in));
  assign ovf_new       = full && ((cls_in == itp_pkg::CLS_OPEN) ||
                                  ((cls_in == itp_pkg::CLS_OP) && !in_top_ge));
  assign open_pushed   = (cls_in == itp_pkg::CLS_OPEN) && !full;
  assign close_matched = (cls_in == itp_pkg::CLS_CLOSE) && (opens_r != '0);
  assign opens_left    = open_pushed ||
                         ((opens_r != '0) && !(close_matched && (opens_r == CW'(1))));
  assign paren_new     = ((cls_in == itp_pkg::CLS_CLOSE) && (opens_r == '0)) ||
                         (in_last && opens_left);

  always_comb begin
    count_nxt = count_r;
    opens_nxt = opens_r;
    if (do_push) begin
      count_nxt = count_r + CW'(1);
      if (push_code == itp_pkg::CODE_OPEN) begin
        opens_nxt = opens_r + CW'(1);
      end
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
      if (top_r == itp_pkg::CODE_OPEN) begin
        opens_nxt = opens_r - CW'(1);
      end
    end
  end

  // Keep the entry just below the new top prefetched
  assign rd_addr = IW'(count_nxt - CW'(2));

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[IW'(count_r)] <= push_code;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      top_r <= push_code;
    end else if (cmd.pop) begin
      top_r <= rd_data_r;
    end
    if (accept) begin
      ch_r   <= in_ch;
      last_r <= in_last;
      cls_r  <= cls_in;
      code_r <= code_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      opens_r   <= '0;
      stopped_r <= 1'b0;
      ovf_r     <= 1'b0;
      paren_r   <= 1'b0;
      emitted_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      opens_r <= opens_nxt;
      if (accept) begin
        stopped_r <= stopped_r || (cls_in == itp_pkg::CLS_OTHER);
        ovf_r     <= ovf_r || ovf_new;
        paren_r   <= paren_r || paren_new;
        emitted_r <= 1'b0;
      end else if (cmd.end_step) begin
        stopped_r <= 1'b0;
        ovf_r     <= 1'b0;
        paren_r   <= 1'b0;
      end else if (cmd.emit) begin
        emitted_r <= 1'b1;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.sel)
        itp_pkg::SEL_CHAR: out_ch_r <= ch_r;
        itp_pkg::SEL_TOP:  out_ch_r <= itp_pkg::code_char(top_r);
        default:           out_ch_r <= itp_pkg::CH_NUL;
      endcase
      out_empty_r <= (cmd.sel == itp_pkg::SEL_MARK);
      out_last_r  <= cmd.emit_last;
      out_ovf_r   <= ovf_r;
      out_paren_r <= paren_r;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.out_ch       = out_ch_r;
  assign out_bus.out_empty    = out_empty_r;
  assign out_bus.out_last     = out_last_r;
  assign out_bus.err_overflow = out_ovf_r;
  assign out_bus.err_paren    = out_paren_r;

  always_comb begin
    stat          = '0;
    stat.in_valid = in_valid;
    stat.cls      = cls_r;
    stat.last     = last_r;
    stat.empty    = (count_r == '0);
    stat.top_open = (top_r == itp_pkg::CODE_OPEN);
    stat.top_ge   = (itp_pkg::prec_of(top_r) >= itp_pkg::prec_of(code_r));
    stat.ops_zero = (ops == '0);
    stat.ops_one  = (ops == CW'(1));
    stat.emitted  = emitted_r;
    stat.out_free = out_free;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_opens_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    opens_r <= count_r)
    else $error("parenthesis count exceeds stack count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("pop on empty stack");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("word loaded over a held result");

  a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.end_step |=> (count_r == '0) && !stopped_r && !ovf_r && !paren_r)
    else $error("expression ended with state left over");
`endif

endmodule

// File: src/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix converter
//
//   channel  | dir | payload                                          | word
//   in_bus   | in  | ch[7:0], last                                    | one infix char
//   out_bus  | out | out_ch[7:0], out_empty, out_last, err_overflow,  | one postfix char
//            |     | err_paren                                        | or end mark
//
// The controller accepts a character in its idle state, then performs one push,
// pop or letter word per step; after the last character it flushes every
// stacked entry and closes the expression. The controller works one character
// at a time. The single output register stalls pops and letter words when the
// sink holds ready low. Reset is synchronous, active low, and empties the stack
// with no clearing pass.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  itp_in_if.sink    in_bus,
  itp_out_if.source out_bus
);

  itp_pkg::cmd_t  cmd;
  itp_pkg::stat_t stat;

  assign in_bus.ready = cmd.in_ready;

  itp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  itp_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ch    (in_bus.ch),
    .in_last  (in_bus.last),
    .cmd      (cmd),
    .stat     (stat),
    .out_bus  (out_bus)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: infix to postfix converter
// Streams infix characters through the converter under random idling on both
// channels. A shunting-yard predictor tracks its own operator stack and error
// flags, and each postfix word on the result channel is checked against the
// oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH     = 16;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    itp_pkg::char_t ch;
    logic           empty;
    logic           last;
    logic           ovf;
    logic           paren;
  } postfix_word_t;

  typedef itp_pkg::char_t char_q_t[$];

  logic clk;
  logic rst_n;

  itp_in_if  in_bus();
  itp_out_if out_bus();

  infix_to_postfix_converter #(
    .STACK_DEPTH(DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // Predictor state
  itp_pkg::code_t op_pending[DEPTH];
  int             op_depth;
  bit             conv_halted;
  bit             ovf_flag;
  bit             paren_flag;
  postfix_word_t  postfix_q[$];

  // Run statistics
  int chars_used;
  int exprs_done;
  int words_checked;
  int errors;
  int n_ovf;
  int n_paren;
  int n_halt;

  // Idling controls
  bit src_idling  = 1'b1;
  bit sink_idling = 1'b1;
  int sink_hold   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int op_rank(itp_pkg::code_t k);
    case (k)
      itp_pkg::CODE_PLUS, itp_pkg::CODE_MINUS: return 2;
      itp_pkg::CODE_MUL, itp_pkg::CODE_DIV:    return 3;
      default:                                 return 0;
    endcase
  endfunction

  function automatic itp_pkg::char_t op_text(itp_pkg::code_t k);
    case (k)
      itp_pkg::CODE_PLUS:  return itp_pkg::CH_PLUS;
      itp_pkg::CODE_MINUS: return itp_pkg::CH_MINUS;
      itp_pkg::CODE_MUL:   return itp_pkg::CH_MUL;
      itp_pkg::CODE_DIV:   return itp_pkg::CH_DIV;
      default:             return itp_pkg::CH_OPEN;
    endcase
  endfunction

  function automatic void push_op(itp_pkg::code_t k);
    if (op_depth >= DEPTH) begin
      ovf_flag = 1'b1;
    end else begin
      op_pending[op_depth] = k;
      op_depth++;
    end
  endfunction

  // Work out the postfix words caused by one accepted character.
  function automatic void predict_step(itp_pkg::char_t c, logic lst);
    itp_pkg::char_t emitted[$];
    itp_pkg::code_t code;
    bit             is_op;
    postfix_word_t  w;
    is_op = 1'b0;
    code  = itp_pkg::CODE_OPEN;
    if (!conv_halted) begin
      chars_used++;
      if ((c >= itp_pkg::CH_LO_A && c <= itp_pkg::CH_LO_Z) ||
          (c >= itp_pkg::CH_UP_A && c <= itp_pkg::CH_UP_Z)) begin
        emitted = {emitted, c};
      end else begin
        case (c)
          itp_pkg::CH_OPEN:  push_op(itp_pkg::CODE_OPEN);
          itp_pkg::CH_CLOSE: begin
            while (op_depth > 0 && op_pending[op_depth-1] != itp_pkg::CODE_OPEN) begin
              op_depth--;
              emitted = {emitted, op_text(op_pending[op_depth])};
            end
            if (op_depth > 0) op_depth--;
            else paren_flag = 1'b1;
          end
          itp_pkg::CH_PLUS:  begin code = itp_pkg::CODE_PLUS;  is_op = 1'b1; end
          itp_pkg::CH_MINUS: begin code = itp_pkg::CODE_MINUS; is_op = 1'b1; end
          itp_pkg::CH_MUL:   begin code = itp_pkg::CODE_MUL;   is_op = 1'b1; end
          itp_pkg::CH_DIV:   begin code = itp_pkg::CODE_DIV;   is_op = 1'b1; end
          default:           conv_halted = 1'b1;
        endcase
        if (is_op) begin
          while (op_depth > 0 && op_rank(op_pending[op_depth-1]) >= op_rank(code)) begin
            op_depth--;
            emitted = {emitted, op_text(op_pending[op_depth])};
          end
          push_op(code);
        end
      end
    end
    // Flush; an open parenthesis left over is dropped and flagged
    if (lst) begin
      while (op_depth > 0) begin
        op_depth--;
        if (op_pending[op_depth] == itp_pkg::CODE_OPEN) paren_flag = 1'b1;
        else emitted = {emitted, op_text(op_pending[op_depth])};
      end
    end
    foreach (emitted[k]) begin
      w.ch    = emitted[k];
      w.empty = 1'b0;
      w.last  = lst && (k == emitted.size() - 1);
      w.ovf   = ovf_flag;
      w.paren = paren_flag;
      postfix_q = {postfix_q, w};
    end
    if (lst && emitted.size() == 0) begin
      w.ch    = itp_pkg::CH_NUL;
      w.empty = 1'b1;
      w.last  = 1'b1;
      w.ovf   = ovf_flag;
      w.paren = paren_flag;
      postfix_q = {postfix_q, w};
    end
    if (lst) begin
      exprs_done++;
      if (ovf_flag) n_ovf++;
      if (paren_flag) n_paren++;
      if (conv_halted) n_halt++;
      op_depth    = 0;
      conv_halted = 1'b0;
      ovf_flag    = 1'b0;
      paren_flag  = 1'b0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic itp_pkg::char_t random_letter();
    int r;
    r = $urandom_range(0, 51);
    if (r < 26) return itp_pkg::char_t'(itp_pkg::CH_LO_A + r);
    return itp_pkg::char_t'(itp_pkg::CH_UP_A + r - 26);
  endfunction

  function automatic itp_pkg::char_t random_op();
    case ($urandom_range(0, 3))
      0:       return itp_pkg::CH_PLUS;
      1:       return itp_pkg::CH_MINUS;
      2:       return itp_pkg::CH_MUL;
      default: return itp_pkg::CH_DIV;
    endcase
  endfunction

  // Mostly well-formed expressions; some nest deep enough to overflow the
  // stack, some are corrupted and a few are pure noise.
  function automatic char_q_t make_expression();
    char_q_t q;
    int      kind;
    int      n_terms;
    int      opens;
    int      open_cap;
    int      open_pct;
    int      close_pct;
    int      pos;
    bit      deep;
    kind = $urandom_range(0, 99);
    if (kind >= 95) begin
      repeat ($urandom_range(1, 5)) q = {q, itp_pkg::char_t'($urandom_range(0, 255))};
      return q;
    end
    deep      = (kind >= 80 && kind < 88);
    open_cap  = deep ? 20 : 4;
    open_pct  = deep ? 65 : 20;
    close_pct = deep ? 15 : 35;
    n_terms   = deep ? $urandom_range(6, 12) : $urandom_range(1, 7);
    opens     = 0;
    for (int i = 0; i < n_terms; i++) begin
      while (opens < open_cap && $urandom_range(0, 99) < open_pct) begin
        q = {q, itp_pkg::CH_OPEN};
        opens++;
      end
      q = {q, random_letter()};
      while (opens > 0 && $urandom_range(0, 99) < close_pct) begin
        q = {q, itp_pkg::CH_CLOSE};
        opens--;
      end
      if (i < n_terms - 1) q = {q, random_op()};
    end
    while (opens > 0) begin
      q = {q, itp_pkg::CH_CLOSE};
      opens--;
    end
    if (kind >= 88) begin
      pos = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 3))
        0: q[pos] = itp_pkg::CH_OPEN;
        1: q[pos] = itp_pkg::CH_CLOSE;
        2: q[pos] = itp_pkg::char_t'($urandom_range(0, 255));
        default: if (q.size() > 1) q.delete(pos);
      endcase
    end
    return q;
  endfunction

  // Offer one word and hold it until the converter takes it.
  task automatic send_char(itp_pkg::char_t c, logic lst);
    int gap;
    gap = src_idling ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.ch    <= c;
    in_bus.last  <= lst;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_step(c, lst);
  endtask

  task automatic send_expr(char_q_t q);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(itp_pkg::char_t'(s[i]), i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (postfix_q.size() != 0) @(posedge clk);
  endtask

  function automatic void note_failure(string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Result side: random stalls plus a long hold-off on request
  initial begin : sink_side
    int gap;
    gap = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_bus.ready <= 1'b0;
        sink_hold--;
      end else if (gap > 0) begin
        out_bus.ready <= 1'b0;
        gap--;
      end else begin
        out_bus.ready <= 1'b1;
        if (sink_idling) gap = pick_gap();
      end
    end
  end

  // Fields shown as ch/empty/last/overflow/paren
  always @(posedge clk) begin : check_word
    postfix_word_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      words_checked++;
      if (postfix_q.size() == 0) begin
        note_failure($sformatf("unexpected word ch=%02h empty=%b last=%b",
                               out_bus.out_ch, out_bus.out_empty, out_bus.out_last));
      end else begin
        want = postfix_q.pop_front();
        if (out_bus.out_ch !== want.ch || out_bus.out_empty !== want.empty ||
            out_bus.out_last !== want.last || out_bus.err_overflow !== want.ovf ||
            out_bus.err_paren !== want.paren) begin
          note_failure($sformatf("mismatch: expected %02h/%b/%b/%b/%b got %02h/%b/%b/%b/%b",
            want.ch, want.empty, want.last, want.ovf, want.paren,
            out_bus.out_ch, out_bus.out_empty, out_bus.out_last,
            out_bus.err_overflow, out_bus.err_paren));
        end
      end
    end
  end

  // All four operators, equal-precedence pops on both levels, nesting
  task automatic test_precedence_and_parens();
    send_text("A-(b*c/d)+Z");
    wait_drained();
  endtask

  // Stray close with an empty stack, then an open never closed
  task automatic test_paren_errors();
    send_text(")");
    send_text("(a");
    wait_drained();
  endtask

  // An unknown character halts conversion; later words are dropped
  task automatic test_unknown_char();
    send_char(itp_pkg::CH_LO_A, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(itp_pkg::CH_OPEN, 1'b1);
    send_char(itp_pkg::CH_NUL, 1'b1);
    wait_drained();
  endtask

  // Fill the stack, then push once more
  task automatic test_stack_overflow();
    repeat (DEPTH) send_char(itp_pkg::CH_OPEN, 1'b0);
    send_char(itp_pkg::CH_MUL, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_expressions(int target);
    int start;
    start = chars_used;
    while (chars_used - start < target) send_expr(make_expression());
    wait_drained();
  endtask

  // Hold the result side off while words keep coming
  task automatic test_output_backpressure();
    int start;
    start      = chars_used;
    src_idling = 1'b0;
    sink_hold  = 300;
    while (chars_used - start < 50) send_expr(make_expression());
    src_idling = 1'b1;
    wait_drained();
  endtask

  task automatic test_back_to_back();
    int start;
    start       = chars_used;
    src_idling  = 1'b0;
    sink_idling = 1'b0;
    while (chars_used - start < 40) send_expr(make_expression());
    src_idling  = 1'b1;
    sink_idling = 1'b1;
    wait_drained();
  endtask

  initial begin
    in_bus.valid <= 1'b0;
    in_bus.ch    <= itp_pkg::CH_NUL;
    in_bus.last  <= 1'b0;
    rst_n        <= 1'b0;
    op_depth     = 0;
    conv_halted  = 1'b0;
    ovf_flag     = 1'b0;
    paren_flag   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_precedence_and_parens();
    test_paren_errors();
    test_unknown_char();
    test_stack_overflow();
    test_random_expressions(360);
    test_output_backpressure();
    test_back_to_back();

    repeat (40) @(posedge clk);
    $display("Converted %0d characters in %0d expressions, %0d postfix words checked",
             chars_used, exprs_done, words_checked);
    $display("Expressions with overflow %0d, paren errors %0d, halted %0d; mismatches %0d",
             n_ovf, n_paren, n_halt, errors);
    if (errors == 0 && postfix_q.size() == 0) begin
      $display("infix_to_postfix_converter test passed");
    end else begin
      $display("infix_to_postfix_converter test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #40ms;
    $display("Timeout with %0d words outstanding", postfix_q.size());
    $display("infix_to_postfix_converter test failed");
    $finish;
  end

endmodule
